// ----- rtl/mlr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasterizer package
// Widths, operation codes and line case codes shared by the rasterizer files.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEC_BITS   = COORD_BITS + 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CASE_RISE_SHALLOW = 2'd0,
    CASE_RISE_STEEP   = 2'd1,
    CASE_FALL_SHALLOW = 2'd2,
    CASE_FALL_STEEP   = 2'd3
  } line_case_t;

endpackage
`default_nettype wire

// ----- rtl/mlr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasterizer channels
// Valid/ready channels for line commands and for pixels.
// ----------------------------------------------------------------------------
interface mlr_cmd_if;
  logic           valid;
  logic           ready;
  mlr_pkg::op_t   op;
  mlr_pkg::coord_t start_x;
  mlr_pkg::coord_t start_y;
  mlr_pkg::coord_t end_x;
  mlr_pkg::coord_t end_y;

  modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface mlr_pix_if;
  logic            valid;
  logic            ready;
  mlr_pkg::coord_t pixel_x;
  mlr_pkg::coord_t pixel_y;
  logic            last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/midpoint_line_rasterizer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasterizer
// Turns two endpoints into a stream of pixels, one pixel per advance word.
// ----------------------------------------------------------------------------
// A start word loads a line and returns its first pixel; each advance word
// returns the next pixel, and the final pixel carries last. An advance word
// with no line loaded returns nothing. Each accepted word is handled in a
// single update, and its pixel is registered and appears on the output in the
// cycle after the word is taken, so the block takes one word per cycle as long
// as the pixel side keeps taking words; that rate is set by the single add and
// compare that updates the decision register and the current pixel per word.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_unit (
  input  wire        clk,
  input  wire        rst,
  mlr_cmd_if.sink    line_in,
  mlr_pix_if.source  pixel_out
);

  logic                active;
  mlr_pkg::coord_t     cur_x;
  mlr_pkg::coord_t     cur_y;
  mlr_pkg::coord_t     stop_x;
  mlr_pkg::coord_t     stop_y;
  mlr_pkg::dec_t       decision;
  mlr_pkg::dec_t       inc_straight;
  mlr_pkg::dec_t       inc_diagonal;
  mlr_pkg::line_case_t case_select;
  logic                out_valid;

  logic                active_next;
  mlr_pkg::coord_t     cur_x_next;
  mlr_pkg::coord_t     cur_y_next;
  mlr_pkg::coord_t     stop_x_next;
  mlr_pkg::coord_t     stop_y_next;
  mlr_pkg::dec_t       decision_next;
  mlr_pkg::dec_t       inc_straight_next;
  mlr_pkg::dec_t       inc_diagonal_next;
  mlr_pkg::line_case_t case_select_next;
  logic                out_valid_next;

  logic                in_acc;
  logic                swap;
  mlr_pkg::coord_t     ax;
  mlr_pkg::coord_t     ay;
  mlr_pkg::coord_t     bx;
  mlr_pkg::coord_t     by;
  mlr_pkg::dec_t       dx;
  mlr_pkg::dec_t       dy;
  mlr_pkg::dec_t       ady;
  logic                steep;
  logic                dec_pos;
  logic                more;

  assign line_in.ready = !out_valid || pixel_out.ready;
  assign in_acc        = line_in.valid && line_in.ready;

  // sort endpoints by x, then by y
  always_comb begin
    swap = (line_in.start_x > line_in.end_x) ||
           ((line_in.start_x == line_in.end_x) && (line_in.start_y > line_in.end_y));
    ax   = swap ? line_in.end_x   : line_in.start_x;
    ay   = swap ? line_in.end_y   : line_in.start_y;
    bx   = swap ? line_in.start_x : line_in.end_x;
    by   = swap ? line_in.start_y : line_in.end_y;
    dx   = mlr_pkg::dec_t'(bx) - mlr_pkg::dec_t'(ax);
    dy   = mlr_pkg::dec_t'(by) - mlr_pkg::dec_t'(ay);
    ady  = dy[mlr_pkg::DEC_BITS-1] ? -dy : dy;
    steep = ady >= dx;
  end

  always_comb begin
    active_next       = active;
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    stop_x_next       = stop_x;
    stop_y_next       = stop_y;
    decision_next     = decision;
    inc_straight_next = inc_straight;
    inc_diagonal_next = inc_diagonal;
    case_select_next  = case_select;
    out_valid_next    = out_valid && !pixel_out.ready;
    dec_pos           = decision > 0;
    more              = 1'b0;

    if (in_acc) begin
      if (line_in.op == mlr_pkg::OP_START) begin
        cur_x_next  = ax;
        cur_y_next  = ay;
        stop_x_next = bx;
        stop_y_next = by;
        if (!dy[mlr_pkg::DEC_BITS-1]) begin
          inc_diagonal_next = (dy - dx) <<< 1;
          if (steep) begin
            inc_straight_next = -(dx <<< 1);
            decision_next     = dy - (dx <<< 1);
            case_select_next  = mlr_pkg::CASE_RISE_STEEP;
          end else begin
            inc_straight_next = dy <<< 1;
            decision_next     = (dy <<< 1) - dx;
            case_select_next  = mlr_pkg::CASE_RISE_SHALLOW;
          end
        end else begin
          inc_diagonal_next = (dy + dx) <<< 1;
          if (steep) begin
            inc_straight_next = dx <<< 1;
            decision_next     = dy + (dx <<< 1);
            case_select_next  = mlr_pkg::CASE_FALL_STEEP;
          end else begin
            inc_straight_next = dy <<< 1;
            decision_next     = (dy <<< 1) + dx;
            case_select_next  = mlr_pkg::CASE_FALL_SHALLOW;
          end
        end
        out_valid_next = 1'b1;
      end else if (active) begin
        unique case (case_select)
          mlr_pkg::CASE_RISE_SHALLOW: begin
            if (!dec_pos) begin
              decision_next = decision + inc_straight;
            end else begin
              decision_next = decision + inc_diagonal;
              cur_y_next    = cur_y + mlr_pkg::coord_t'(1);
            end
            cur_x_next = cur_x + mlr_pkg::coord_t'(1);
          end
          mlr_pkg::CASE_RISE_STEEP: begin
            if (dec_pos) begin
              decision_next = decision + inc_straight;
            end else begin
              decision_next = decision + inc_diagonal;
              cur_x_next    = cur_x + mlr_pkg::coord_t'(1);
            end
            cur_y_next = cur_y + mlr_pkg::coord_t'(1);
          end
          mlr_pkg::CASE_FALL_SHALLOW: begin
            if (dec_pos) begin
              decision_next = decision + inc_straight;
            end else begin
              decision_next = decision + inc_diagonal;
              cur_y_next    = cur_y - mlr_pkg::coord_t'(1);
            end
            cur_x_next = cur_x + mlr_pkg::coord_t'(1);
          end
          mlr_pkg::CASE_FALL_STEEP: begin
            if (!dec_pos) begin
              decision_next = decision + inc_straight;
            end else begin
              decision_next = decision + inc_diagonal;
              cur_x_next    = cur_x + mlr_pkg::coord_t'(1);
            end
            cur_y_next = cur_y - mlr_pkg::coord_t'(1);
          end
          default: begin
            decision_next = decision;
          end
        endcase
        out_valid_next = 1'b1;
      end

      if ((line_in.op == mlr_pkg::OP_START) || active) begin
        unique case (case_select_next)
          mlr_pkg::CASE_RISE_STEEP: more = cur_y_next < stop_y_next;
          mlr_pkg::CASE_FALL_STEEP: more = cur_y_next > stop_y_next;
          default:                  more = cur_x_next < stop_x_next;
        endcase
        active_next = more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      out_valid    <= 1'b0;
      cur_x        <= '0;
      cur_y        <= '0;
      stop_x       <= '0;
      stop_y       <= '0;
      decision     <= '0;
      inc_straight <= '0;
      inc_diagonal <= '0;
      case_select  <= mlr_pkg::CASE_RISE_SHALLOW;
    end else begin
      active       <= active_next;
      out_valid    <= out_valid_next;
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      stop_x       <= stop_x_next;
      stop_y       <= stop_y_next;
      decision     <= decision_next;
      inc_straight <= inc_straight_next;
      inc_diagonal <= inc_diagonal_next;
      case_select  <= case_select_next;
    end
  end

  // the held pixel is the current pixel; it is final exactly when no line remains
  assign pixel_out.valid   = out_valid;
  assign pixel_out.pixel_x = cur_x;
  assign pixel_out.pixel_y = cur_y;
  assign pixel_out.last    = !active;

  a_start_emits: assert property (@(posedge clk) disable iff (rst)
    in_acc && (line_in.op == mlr_pkg::OP_START) |=> out_valid)
    else $error("start word produced no pixel");

  a_idle_advance_holds: assert property (@(posedge clk) disable iff (rst)
    in_acc && (line_in.op == mlr_pkg::OP_ADVANCE) && !active
    |=> $stable(cur_x) && $stable(cur_y) && !active)
    else $error("advance with no line changed state");

  a_shallow_before_stop: assert property (@(posedge clk) disable iff (rst)
    active && ((case_select == mlr_pkg::CASE_RISE_SHALLOW) ||
               (case_select == mlr_pkg::CASE_FALL_SHALLOW)) |-> cur_x < stop_x)
    else $error("shallow line active past its end");

  a_steep_rise_before_stop: assert property (@(posedge clk) disable iff (rst)
    active && (case_select == mlr_pkg::CASE_RISE_STEEP) |-> cur_y < stop_y)
    else $error("steep rising line active past its end");

endmodule
`default_nettype wire
